/* rtl/dsqrt_pkg.sv */
package dsqrt_pkg;

  // Field and bus widths
  localparam int unsigned RADICAND_W = 48;
  localparam int unsigned ROOT_OUT_W = 43;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ALIGN,
    ST_ROOT,
    ST_HOLD
  } dsqrt_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new radicand, clear root and remainder
    logic mul10;      // multiply the working value by ten
    logic align;      // drop the input fraction bits
    logic root_step;  // resolve one root bit
    logic out_load;   // move the finished root into the output register
  } dsqrt_cmd_t;

endpackage : dsqrt_pkg

/* rtl/decimal_digit_square_root.sv */
// Decimal square root: floor(sqrt(x * 10^(2*DECIMAL_PLACES) / 2^INPUT_FRACTION_BITS)).
// Steps: the times-ten scaling loop scales the radicand, the input fraction bits are dropped,
//   then the restoring root unit resolves ROOT_W = 24 + 4*DECIMAL_PLACES root bits, one per cycle.
// The output register is loaded only once the previous result has been taken; a new radicand
//   is accepted only in idle, after the previous root has been moved to the output register.
// Reset (rst_ni, async, active low) returns the controller to idle and empties the output.
module decimal_digit_square_root #(
  parameter int unsigned DECIMAL_PLACES      = 8,
  parameter int unsigned INPUT_FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [dsqrt_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,  // [47:0] radicand
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [dsqrt_pkg::M_TDATA_W-1:0]    m_axis_tdata_o   // [42:0] root_scaled, rest zero
);
  import dsqrt_pkg::*;

  dsqrt_cmd_t            cmd;
  logic [ROOT_OUT_W-1:0] root_scaled;

  // Controller: sequences load, scale, align, root steps, and the output register.
  // A new radicand is taken while the previous result still waits for its transfer.
  dsqrt_ctrl #(
    .DECIMAL_PLACES (DECIMAL_PLACES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  // Datapath: wide scaling register, remainder and partial root, result register.
  dsqrt_dp #(
    .DECIMAL_PLACES      (DECIMAL_PLACES),
    .INPUT_FRACTION_BITS (INPUT_FRACTION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .radicand_i    (s_axis_tdata_i[RADICAND_W-1:0]),
    .root_scaled_o (root_scaled)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata_o = M_TDATA_W'(root_scaled);

endmodule : decimal_digit_square_root

/* rtl/dsqrt_dp.sv */
module dsqrt_dp #(
  parameter int unsigned DECIMAL_PLACES      = 8,
  parameter int unsigned INPUT_FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  dsqrt_pkg::dsqrt_cmd_t                cmd_i,
  input  logic [dsqrt_pkg::RADICAND_W-1:0]     radicand_i,
  output logic [dsqrt_pkg::ROOT_OUT_W-1:0]     root_scaled_o
);
  import dsqrt_pkg::*;

  // 10 < 16, so 10^(2*D) fits in 8*D bits
  localparam int unsigned PROD_W = RADICAND_W + 8 * DECIMAL_PLACES;
  localparam int unsigned ROOT_W = PROD_W / 2;
  localparam int unsigned EXT_W  = (ROOT_W > ROOT_OUT_W) ? ROOT_W : ROOT_OUT_W;

  logic [PROD_W-1:0]     v_q, v_d;
  logic [ROOT_W:0]       rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_OUT_W-1:0] res_q, res_d;

  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     tsub;
  logic [ROOT_W+2:0]     diff;
  logic                  take;
  logic [EXT_W-1:0]      root_ext;
  logic                  sat;

  // Restoring root step: bring down two radicand bits, test 4*root+1
  assign trial = {rem_q, v_q[PROD_W-1 -: 2]};
  assign tsub  = {1'b0, root_q, 2'b01};
  assign take  = (trial >= tsub);
  assign diff  = trial - tsub;

  assign root_ext = EXT_W'(root_q);
  assign sat      = ((root_ext >> ROOT_OUT_W) != '0);

  always_comb begin
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    res_d  = res_q;
    if (cmd_i.load) begin
      v_d    = PROD_W'(radicand_i);
      rem_d  = '0;
      root_d = '0;
    end
    if (cmd_i.mul10) begin
      v_d = {v_q[PROD_W-4:0], 3'b000} + {v_q[PROD_W-2:0], 1'b0};
    end
    if (cmd_i.align) begin
      v_d = v_q >> INPUT_FRACTION_BITS;
    end
    if (cmd_i.root_step) begin
      v_d    = {v_q[PROD_W-3:0], 2'b00};
      rem_d  = take ? diff[ROOT_W:0] : trial[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], take};
    end
    if (cmd_i.out_load) begin
      res_d = sat ? '1 : root_ext[ROOT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  assign root_scaled_o = res_q;

endmodule : dsqrt_dp

/* rtl/dsqrt_ctrl.sv */
module dsqrt_ctrl #(
  parameter int unsigned DECIMAL_PLACES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output dsqrt_pkg::dsqrt_cmd_t cmd_o
);
  import dsqrt_pkg::*;

  localparam int unsigned PROD_W     = RADICAND_W + 8 * DECIMAL_PLACES;
  localparam int unsigned ROOT_STEPS = PROD_W / 2;
  localparam int unsigned MUL_STEPS  = 2 * DECIMAL_PLACES;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

  dsqrt_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             s_fire;
  logic             out_free;

  assign s_fire   = s_valid_i && s_ready_o;
  assign out_free = !out_valid_q || m_ready_i;

  // Next state and counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_SCALE;
          cnt_d   = CNT_W'(MUL_STEPS - 1);
        end
      end
      ST_SCALE: begin
        if (cnt_q == '0) begin
          state_d = ST_ALIGN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ALIGN: begin
        state_d = ST_ROOT;
        cnt_d   = CNT_W'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        if (cnt_q == '0) begin
          state_d = ST_HOLD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and handshakes
  always_comb begin
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_SCALE: cmd_o.mul10     = 1'b1;
      ST_ALIGN: cmd_o.align     = 1'b1;
      ST_ROOT:  cmd_o.root_step = 1'b1;
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

  a_accept_starts_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_SCALE) && (cnt_q == CNT_W'(MUL_STEPS - 1)))
    else $error("accepted item did not start scaling");

  a_align_starts_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN) |=> (state_q == ST_ROOT) && (cnt_q == CNT_W'(ROOT_STEPS - 1)))
    else $error("root phase did not start with a full step count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("result register overwritten before transfer");

  a_load_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && (state_q == ST_IDLE))
    else $error("loaded result not presented");

endmodule : dsqrt_ctrl
